### hdl/bawh_pkg.sv
// Shared definitions for the best-arm win histogram: sizes, register indexes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package bawh_pkg;

    // Block sizing
    localparam int NUM_WTP    = 4;
    localparam int MAX_ARMS   = 16;
    localparam int COUNT_BITS = 24;

    // Field widths
    localparam int WTP_W      = 24;
    localparam int EFFECT_W   = 32;
    localparam int COST_W     = 48;
    localparam int NB_W       = WTP_W + 1 + EFFECT_W;
    localparam int WIDX_W     = (NUM_WTP > 1) ? $clog2(NUM_WTP) : 1;
    localparam int AIDX_W     = $clog2(MAX_ARMS);
    localparam int NWTP_W     = $clog2(NUM_WTP + 1);
    localparam int NARM_W     = $clog2(MAX_ARMS + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_WTP_REG_W  = 3;
    localparam int NUM_ARMS_REG_W = 5;
    localparam int FRAC_W     = 16;
    localparam int PROP_W     = FRAC_W + 1;
    localparam int DIV_CNT_W  = $clog2(PROP_W + 1);
    localparam int ADDR_W     = WIDX_W + AIDX_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;

    typedef logic        [WTP_W-1:0]          wtp_t;
    typedef logic signed [EFFECT_W-1:0]       effect_t;
    typedef logic signed [COST_W-1:0]         cost_t;
    typedef logic signed [NB_W-1:0]           nb_t;
    typedef logic        [WIDX_W-1:0]         widx_t;
    typedef logic        [AIDX_W-1:0]         aidx_t;
    typedef logic        [NWTP_W-1:0]         nwtp_t;
    typedef logic        [NARM_W-1:0]         narm_t;
    typedef logic        [COUNT_BITS-1:0]     cnt_t;
    typedef logic        [PROP_W-1:0]         prop_t;
    typedef logic        [ADDR_W-1:0]         addr_t;
    typedef logic        [CFG_IDX_W-1:0]      cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0]     cfg_data_t;
    typedef logic        [NUM_WTP_REG_W-1:0]  num_wtp_t;
    typedef logic        [NUM_ARMS_REG_W-1:0] num_arms_t;
    typedef logic        [DIV_CNT_W-1:0]      div_cnt_t;

    localparam cnt_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // Configuration register indexes
    localparam cfg_idx_t CFG_WTP_0    = 3'd0;
    localparam cfg_idx_t CFG_WTP_1    = 3'd1;
    localparam cfg_idx_t CFG_WTP_2    = 3'd2;
    localparam cfg_idx_t CFG_WTP_3    = 3'd3;
    localparam cfg_idx_t CFG_NUM_WTP  = 3'd4;
    localparam cfg_idx_t CFG_NUM_ARMS = 3'd5;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_LAST,
        ST_WIN,
        ST_WIN_WB,
        ST_RPT_RD,
        ST_RPT_LD,
        ST_RPT_DIV,
        ST_RPT_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  load;       // capture the input item
        logic  mul_en;     // multiply wtp[mul_w] by the effect
        widx_t mul_w;
        logic  sim_end;    // simulation complete: bump sim count, rewind arm
        logic  arm_adv;    // next arm of the same simulation
        logic  win_rd;     // read win count of (rd_w, best arm) for increment
        logic  rpt_rd;     // read win count of (rd_w, rd_a) for the report
        widx_t rd_w;
        aidx_t rd_a;
        logic  rd_last;    // this report entry is the final one
        logic  div_start;  // latch report fields and start the divider
        logic  rpt_done;   // clear win counts and sim count
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        nwtp_t eff_nw;
        narm_t eff_arms;
        logic  sim_done;   // current item completes a simulation
        logic  final_sim;
        logic  div_busy;
    } dp_sts_t;

endpackage

`default_nettype wire

### hdl/bawh_div.sv
// Serial restoring divider for the report: floor(count * 2^16 / sims), one
// quotient bit per cycle. Depends on bawh_pkg.
`default_nettype none

module bawh_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire bawh_pkg::cnt_t num,
    input  wire bawh_pkg::cnt_t den,
    output logic                busy,
    output bawh_pkg::prop_t     quot
);

    bawh_pkg::cnt_t     rem_reg,  rem_next;
    bawh_pkg::prop_t    low_reg,  low_next;
    bawh_pkg::prop_t    quot_reg, quot_next;
    bawh_pkg::cnt_t     den_reg;
    bawh_pkg::div_cnt_t cnt_reg,  cnt_next;

    logic [bawh_pkg::COUNT_BITS:0] trial;
    logic [bawh_pkg::COUNT_BITS:0] diff;
    logic                          ge;

    // One trial subtraction per step
    always_comb begin
        trial     = {rem_reg, low_reg[bawh_pkg::PROP_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = ge ? diff[bawh_pkg::COUNT_BITS-1:0] : trial[bawh_pkg::COUNT_BITS-1:0];
        low_next  = {low_reg[bawh_pkg::PROP_W-2:0], 1'b0};
        quot_next = {quot_reg[bawh_pkg::PROP_W-2:0], ge};
        cnt_next  = cnt_reg - bawh_pkg::div_cnt_t'(1);
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= bawh_pkg::div_cnt_t'(bawh_pkg::PROP_W);
        end else if (busy) begin
            cnt_reg <= cnt_next;
        end
    end

    // Load the high dividend bits as the partial remainder, shift in the rest
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num >> 1;
            low_reg  <= {num[0], {bawh_pkg::FRAC_W{1'b0}}};
            quot_reg <= '0;
            den_reg  <= den;
        end else if (busy) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quot_reg <= quot_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule

`default_nettype wire

### hdl/bawh_dp.sv
// Datapath: configuration registers, shared wtp multiplier, running maxima,
// win count memory and report output registers. Depends on bawh_pkg, bawh_div.
`default_nettype none

module bawh_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire bawh_pkg::cfg_idx_t  cfg_index,
    input  wire bawh_pkg::cfg_data_t cfg_data,
    input  wire bawh_pkg::effect_t   s_effect,
    input  wire bawh_pkg::cost_t     s_cost,
    input  wire logic                s_final_sim,
    input  wire bawh_pkg::dp_cmd_t   cmd,
    output bawh_pkg::dp_sts_t        sts,
    output bawh_pkg::widx_t          m_wtp_index,
    output bawh_pkg::aidx_t          m_arm_index,
    output bawh_pkg::cnt_t           m_win_count,
    output bawh_pkg::prop_t          m_proportion,
    output logic                     m_last
);

    // Configuration
    bawh_pkg::wtp_t      wtp_reg [bawh_pkg::NUM_WTP];
    bawh_pkg::num_wtp_t  num_wtp_reg;
    bawh_pkg::num_arms_t num_arms_reg;
    bawh_pkg::nwtp_t     eff_nw;
    bawh_pkg::narm_t     eff_arms;

    // Item and running maxima
    bawh_pkg::effect_t   effect_reg;
    bawh_pkg::cost_t     cost_reg;
    logic                final_reg;
    bawh_pkg::effect_t   mul_op;
    bawh_pkg::nb_t       prod_reg;
    bawh_pkg::widx_t     prod_w_reg;
    logic                prod_vld_reg;
    bawh_pkg::nb_t       nb;
    bawh_pkg::nb_t       best_nb_reg  [bawh_pkg::NUM_WTP];
    bawh_pkg::aidx_t     best_arm_reg [bawh_pkg::NUM_WTP];
    bawh_pkg::aidx_t     arm_pos_reg;
    bawh_pkg::cnt_t      sim_count_reg;

    // Win count memory
    bawh_pkg::cnt_t      win_mem [bawh_pkg::MEM_DEPTH];
    logic [bawh_pkg::MEM_DEPTH-1:0] win_vld_reg;
    bawh_pkg::addr_t     rd_addr;
    logic                rd_en;
    bawh_pkg::cnt_t      rd_data_reg;
    logic                rd_hit_reg;
    bawh_pkg::cnt_t      rd_count;
    logic                wb_pend_reg;
    bawh_pkg::addr_t     wb_addr_reg;
    bawh_pkg::cnt_t      wb_data;

    // Report
    bawh_pkg::widx_t     out_w_reg;
    bawh_pkg::aidx_t     out_a_reg;
    bawh_pkg::cnt_t      out_count_reg;
    logic                out_last_reg;
    bawh_pkg::prop_t     quot;
    logic                div_busy;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bawh_pkg::NUM_WTP; i++) begin
                wtp_reg[i] <= '0;
            end
            num_wtp_reg  <= bawh_pkg::num_wtp_t'(1);
            num_arms_reg <= bawh_pkg::num_arms_t'(2);
        end else if (cfg_valid) begin
            unique case (cfg_index) inside
                bawh_pkg::CFG_WTP_0, bawh_pkg::CFG_WTP_1,
                bawh_pkg::CFG_WTP_2, bawh_pkg::CFG_WTP_3: begin
                    if (int'(cfg_index) < bawh_pkg::NUM_WTP) begin
                        wtp_reg[cfg_index[bawh_pkg::WIDX_W-1:0]] <= cfg_data;
                    end
                end
                bawh_pkg::CFG_NUM_WTP: begin
                    num_wtp_reg <= cfg_data[bawh_pkg::NUM_WTP_REG_W-1:0];
                end
                bawh_pkg::CFG_NUM_ARMS: begin
                    num_arms_reg <= cfg_data[bawh_pkg::NUM_ARMS_REG_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Clamp the count registers to their usable range
    always_comb begin
        if (num_wtp_reg == '0) begin
            eff_nw = bawh_pkg::nwtp_t'(1);
        end else if (int'(num_wtp_reg) > bawh_pkg::NUM_WTP) begin
            eff_nw = bawh_pkg::nwtp_t'(bawh_pkg::NUM_WTP);
        end else begin
            eff_nw = bawh_pkg::nwtp_t'(num_wtp_reg);
        end
        if (num_arms_reg == '0) begin
            eff_arms = bawh_pkg::narm_t'(1);
        end else if (int'(num_arms_reg) > bawh_pkg::MAX_ARMS) begin
            eff_arms = bawh_pkg::narm_t'(bawh_pkg::MAX_ARMS);
        end else begin
            eff_arms = bawh_pkg::narm_t'(num_arms_reg);
        end
    end

    // Capture the item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            effect_reg <= s_effect;
            cost_reg   <= s_cost;
            final_reg  <= s_final_sim;
        end
    end

    // Shared multiplier: the first product takes the effect straight from the port
    assign mul_op = cmd.load ? s_effect : effect_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg   <= $signed({1'b0, wtp_reg[cmd.mul_w]}) * mul_op;
            prod_w_reg <= cmd.mul_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    // Net benefit and running maximum; the first arm always takes it, ties keep the old one
    assign nb = prod_reg - bawh_pkg::nb_t'(cost_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bawh_pkg::NUM_WTP; i++) begin
                best_nb_reg[i]  <= '0;
                best_arm_reg[i] <= '0;
            end
        end else if (prod_vld_reg) begin
            if ((arm_pos_reg == '0) || (nb > best_nb_reg[prod_w_reg])) begin
                best_nb_reg[prod_w_reg]  <= nb;
                best_arm_reg[prod_w_reg] <= arm_pos_reg;
            end
        end
    end

    // Arm position and saturating simulation count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arm_pos_reg   <= '0;
            sim_count_reg <= '0;
        end else begin
            if (cmd.sim_end) begin
                arm_pos_reg <= '0;
            end else if (cmd.arm_adv) begin
                arm_pos_reg <= arm_pos_reg + bawh_pkg::aidx_t'(1);
            end
            if (cmd.rpt_done) begin
                sim_count_reg <= '0;
            end else if (cmd.sim_end && (sim_count_reg != bawh_pkg::COUNT_MAX)) begin
                sim_count_reg <= sim_count_reg + bawh_pkg::cnt_t'(1);
            end
        end
    end

    // Win memory: registered read, write-back of the increment in the cycle after the read
    assign rd_en   = cmd.win_rd | cmd.rpt_rd;
    assign rd_addr = cmd.win_rd ? {cmd.rd_w, best_arm_reg[cmd.rd_w]} : {cmd.rd_w, cmd.rd_a};

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= win_mem[rd_addr];
            rd_hit_reg  <= win_vld_reg[rd_addr];
        end
        if (wb_pend_reg) begin
            win_mem[wb_addr_reg] <= wb_data;
        end
        if (cmd.win_rd) begin
            wb_addr_reg <= rd_addr;
        end
    end

    // Entries never written since the last clear read as zero
    assign rd_count = rd_hit_reg ? rd_data_reg : '0;
    assign wb_data  = (rd_count == bawh_pkg::COUNT_MAX) ? rd_count
                                                        : rd_count + bawh_pkg::cnt_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_pend_reg <= 1'b0;
            win_vld_reg <= '0;
        end else begin
            wb_pend_reg <= cmd.win_rd;
            if (cmd.rpt_done) begin
                win_vld_reg <= '0;
            end else if (wb_pend_reg) begin
                win_vld_reg[wb_addr_reg] <= 1'b1;
            end
        end
    end

    // Proportion divider
    bawh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (rd_count),
        .den     (sim_count_reg),
        .busy    (div_busy),
        .quot    (quot)
    );

    // Hold report fields for the output transfer
    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            out_w_reg     <= cmd.rd_w;
            out_a_reg     <= cmd.rd_a;
            out_count_reg <= rd_count;
            out_last_reg  <= cmd.rd_last;
        end
    end

    assign m_wtp_index  = out_w_reg;
    assign m_arm_index  = out_a_reg;
    assign m_win_count  = out_count_reg;
    assign m_proportion = (sim_count_reg == '0) ? '0 : quot;
    assign m_last       = out_last_reg;

    // Status
    always_comb begin
        sts.eff_nw    = eff_nw;
        sts.eff_arms  = eff_arms;
        sts.sim_done  = ((bawh_pkg::narm_t'(arm_pos_reg) + bawh_pkg::narm_t'(1)) >= eff_arms);
        sts.final_sim = final_reg;
        sts.div_busy  = div_busy;
    end

endmodule

`default_nettype wire

### hdl/bawh_ctrl.sv
// Controller: sequences multiplies per item, win count updates at the end of a
// simulation and the report loop. Depends on bawh_pkg.
`default_nettype none

module bawh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire bawh_pkg::dp_sts_t sts,
    output bawh_pkg::dp_cmd_t      cmd
);

    bawh_pkg::state_t state_reg, state_next;
    bawh_pkg::widx_t  w_reg,     w_next;
    bawh_pkg::aidx_t  a_reg,     a_next;
    logic             last_w;
    logic             last_a;

    // State and loop counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bawh_pkg::ST_IDLE;
            w_reg     <= '0;
            a_reg     <= '0;
        end else begin
            state_reg <= state_next;
            w_reg     <= w_next;
            a_reg     <= a_next;
        end
    end

    assign last_w = ((bawh_pkg::nwtp_t'(w_reg) + bawh_pkg::nwtp_t'(1)) == sts.eff_nw);
    assign last_a = ((bawh_pkg::narm_t'(a_reg) + bawh_pkg::narm_t'(1)) == sts.eff_arms);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        w_next     = w_reg;
        a_next     = a_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        unique case (state_reg)
            bawh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cmd.mul_en = 1'b1;
                    cmd.mul_w  = '0;
                    if (bawh_pkg::NUM_WTP > 1) begin
                        w_next     = bawh_pkg::widx_t'(1);
                        state_next = bawh_pkg::ST_MUL;
                    end else begin
                        state_next = bawh_pkg::ST_LAST;
                    end
                end
            end

            bawh_pkg::ST_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_w  = w_reg;
                if (w_reg == bawh_pkg::widx_t'(bawh_pkg::NUM_WTP - 1)) begin
                    state_next = bawh_pkg::ST_LAST;
                end else begin
                    w_next = w_reg + bawh_pkg::widx_t'(1);
                end
            end

            // Last compare; take the next item here unless the simulation ends
            bawh_pkg::ST_LAST: begin
                if (sts.sim_done) begin
                    cmd.sim_end = 1'b1;
                    w_next      = '0;
                    state_next  = bawh_pkg::ST_WIN;
                end else begin
                    cmd.arm_adv = 1'b1;
                    s_ready     = 1'b1;
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        cmd.mul_en = 1'b1;
                        cmd.mul_w  = '0;
                        if (bawh_pkg::NUM_WTP > 1) begin
                            w_next     = bawh_pkg::widx_t'(1);
                            state_next = bawh_pkg::ST_MUL;
                        end else begin
                            state_next = bawh_pkg::ST_LAST;
                        end
                    end else begin
                        state_next = bawh_pkg::ST_IDLE;
                    end
                end
            end

            bawh_pkg::ST_WIN: begin
                cmd.win_rd = 1'b1;
                cmd.rd_w   = w_reg;
                if (last_w) begin
                    state_next = bawh_pkg::ST_WIN_WB;
                end else begin
                    w_next = w_reg + bawh_pkg::widx_t'(1);
                end
            end

            // Drain the final write-back
            bawh_pkg::ST_WIN_WB: begin
                w_next = '0;
                a_next = '0;
                if (sts.final_sim) begin
                    state_next = bawh_pkg::ST_RPT_RD;
                end else begin
                    state_next = bawh_pkg::ST_IDLE;
                end
            end

            bawh_pkg::ST_RPT_RD: begin
                cmd.rpt_rd = 1'b1;
                cmd.rd_w   = w_reg;
                cmd.rd_a   = a_reg;
                state_next = bawh_pkg::ST_RPT_LD;
            end

            bawh_pkg::ST_RPT_LD: begin
                cmd.div_start = 1'b1;
                cmd.rd_w      = w_reg;
                cmd.rd_a      = a_reg;
                cmd.rd_last   = last_w && last_a;
                state_next    = bawh_pkg::ST_RPT_DIV;
            end

            bawh_pkg::ST_RPT_DIV: begin
                if (!sts.div_busy) begin
                    state_next = bawh_pkg::ST_RPT_OUT;
                end
            end

            // Hold the result until the transfer, then advance arm-minor
            bawh_pkg::ST_RPT_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (last_w && last_a) begin
                        cmd.rpt_done = 1'b1;
                        w_next       = '0;
                        a_next       = '0;
                        state_next   = bawh_pkg::ST_IDLE;
                    end else if (last_a) begin
                        a_next     = '0;
                        w_next     = w_reg + bawh_pkg::widx_t'(1);
                        state_next = bawh_pkg::ST_RPT_RD;
                    end else begin
                        a_next     = a_reg + bawh_pkg::aidx_t'(1);
                        state_next = bawh_pkg::ST_RPT_RD;
                    end
                end
            end

            default: begin
                state_next = bawh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/best_arm_win_histogram.sv
// Best-arm win histogram top level: controller plus datapath.
// Depends on bawh_pkg, bawh_ctrl, bawh_dp.
//
// Usage:
//   Input channel (s_valid/s_ready): one item per arm, num_arms items per
//   simulation, arm 0 first. Each item carries effect (Q16.16), cost (Q32.16)
//   and final_sim.
//   Config channel (cfg_valid/cfg_ready): always ready; index 0..3 wtp values,
//   4 num_wtp, 5 num_arms, others dropped. Write only while the block is idle.
//   Result channel (m_valid/m_ready): after the item that completes a
//   simulation with final_sim set, one result per (wtp, arm), wtp-major, with
//   m_last on the final one; win counts and the simulation count then clear.
// Sequencing:
//   One shared multiplier steps over the NUM_WTP values for each item; the
//   next item is not taken until the multiplies of the last are done. An item
//   that completes a simulation is followed by the win memory update per wtp.
//   Each result is read, loaded into the 17-step serial divider, divided and
//   then offered on the output, where it waits for m_ready; the payload
//   holds while stalled. No input is taken while a report is in progress.
// Reset: synchronous, active low; clears config to its defaults, all win
//   counts, the simulation count and the arm position. No clearing pass.
`default_nettype none

module best_arm_win_histogram (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire bawh_pkg::cfg_idx_t  cfg_index,
    input  wire bawh_pkg::cfg_data_t cfg_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bawh_pkg::effect_t   s_effect,
    input  wire bawh_pkg::cost_t     s_cost,
    input  wire logic                s_final_sim,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bawh_pkg::widx_t          m_wtp_index,
    output bawh_pkg::aidx_t          m_arm_index,
    output bawh_pkg::cnt_t           m_win_count,
    output bawh_pkg::prop_t          m_proportion,
    output logic                     m_last
);

    bawh_pkg::dp_cmd_t cmd;
    bawh_pkg::dp_sts_t sts;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    bawh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bawh_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_effect     (s_effect),
        .s_cost       (s_cost),
        .s_final_sim  (s_final_sim),
        .cmd          (cmd),
        .sts          (sts),
        .m_wtp_index  (m_wtp_index),
        .m_arm_index  (m_arm_index),
        .m_win_count  (m_win_count),
        .m_proportion (m_proportion),
        .m_last       (m_last)
    );

endmodule

`default_nettype wire

### hdl/bawh_chk.sv
// Port-level checker for best_arm_win_histogram, attached by bind.
// Depends on bawh_pkg and the top level's ports.
`default_nettype none

module bawh_chk (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_ready,
    input wire logic            m_valid,
    input wire logic            m_ready,
    input wire bawh_pkg::widx_t m_wtp_index,
    input wire bawh_pkg::aidx_t m_arm_index,
    input wire bawh_pkg::cnt_t  m_win_count,
    input wire bawh_pkg::prop_t m_proportion,
    input wire logic            m_last
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_wtp_index) && $stable(m_arm_index)
            && $stable(m_win_count) && $stable(m_proportion) && $stable(m_last))
        else $error("result changed while stalled");

    // No input transfer while a report is out
    a_no_input_in_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready during report");

    // A proportion never exceeds one
    a_prop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_proportion <= {1'b1, {bawh_pkg::FRAC_W{1'b0}}}))
        else $error("proportion above one");

    // No wins gives a zero proportion
    a_zero_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_win_count == '0) |-> (m_proportion == '0))
        else $error("nonzero proportion for zero wins");

    // The report ends after the last transfer
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("result after last");

endmodule

bind best_arm_win_histogram bawh_chk u_bawh_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_wtp_index  (m_wtp_index),
    .m_arm_index  (m_arm_index),
    .m_win_count  (m_win_count),
    .m_proportion (m_proportion),
    .m_last       (m_last)
);

`default_nettype wire
